@@ hdl/feb_pkg.sv @@
`default_nettype none

package feb_pkg;

  typedef struct packed {
    logic [31:0] left;
    logic [31:0] right;
  } halves_t;

  localparam logic [3:0] SBOX_A [16] = '{
    4'd14, 4'd4, 4'd13, 4'd1, 4'd2, 4'd15, 4'd11, 4'd8,
    4'd3, 4'd10, 4'd6, 4'd12, 4'd5, 4'd9, 4'd0, 4'd7
  };

  localparam logic [3:0] SBOX_B [16] = '{
    4'd5, 4'd6, 4'd12, 4'd15, 4'd8, 4'd10, 4'd0, 4'd4,
    4'd11, 4'd3, 4'd7, 4'd13, 4'd14, 4'd1, 4'd2, 4'd9
  };

  // output position (msb = 0) of each input bit (msb = 0)
  localparam logic [4:0] PERM [32] = '{
    5'd29, 5'd1, 5'd17, 5'd8, 5'd30, 5'd22, 5'd28, 5'd6,
    5'd18, 5'd4, 5'd12, 5'd19, 5'd21, 5'd26, 5'd2, 5'd20,
    5'd31, 5'd10, 5'd9, 5'd25, 5'd13, 5'd0, 5'd23, 5'd15,
    5'd3, 5'd27, 5'd5, 5'd11, 5'd7, 5'd14, 5'd24, 5'd16
  };

  // rotate a 16-bit half left
  function automatic logic [15:0] rot16(input logic [15:0] x, input logic [3:0] r);
    logic [31:0] d;
    d = {x, x} << r;
    return d[31:16];
  endfunction

  function automatic logic [31:0] round_key(input logic [31:0] key, input logic [3:0] r);
    return {rot16(key[31:16], r), rot16(key[15:0], r)};
  endfunction

  // substitution then bit permutation
  function automatic logic [31:0] round_fn(input logic [31:0] x);
    logic [31:0] s;
    logic [31:0] p;
    s = '0;
    p = '0;
    for (int n = 0; n < 8; n++) begin
      if (n % 2 == 0) begin
        s[31 - 4 * n -: 4] = SBOX_A[x[31 - 4 * n -: 4]];
      end else begin
        s[31 - 4 * n -: 4] = SBOX_B[x[31 - 4 * n -: 4]];
      end
    end
    for (int b = 0; b < 32; b++) begin
      p[5'd31 - PERM[b]] = s[31 - b];
    end
    return p;
  endfunction

endpackage

`default_nettype wire

@@ hdl/feb_round.sv @@
`default_nettype none

module feb_round #(
  parameter int ROUND_IDX = 1
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic [31:0]     key,
  input  wire logic            up_valid,
  output      logic            up_ready,
  input  wire feb_pkg::halves_t up_data,
  output      logic            dn_valid,
  input  wire logic            dn_ready,
  output      feb_pkg::halves_t dn_data
);

  localparam logic [3:0] ROT = 4'(ROUND_IDX % 16);

  logic             valid_r;
  logic             valid_nxt;
  feb_pkg::halves_t data_r;
  feb_pkg::halves_t data_nxt;
  logic [31:0]      f;

  assign up_ready = !valid_r || dn_ready;
  assign f        = feb_pkg::round_fn(up_data.right ^ feb_pkg::round_key(key, ROT));

  always_comb begin
    valid_nxt      = up_ready ? up_valid : valid_r;
    data_nxt.left  = up_data.right;
    data_nxt.right = up_data.left ^ f;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // payload loads only on a handshake
  always_ff @(posedge clk) begin
    if (up_valid && up_ready) begin
      data_r <= data_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_data  = data_r;

endmodule

`default_nettype wire

@@ hdl/feistel_block_encrypt_unit.sv @@
// feistel block encryption, one 64-bit word in, one 64-bit word out
// in channel: in_valid / in_ready / in_plaintext, left half in the upper 32 bits
// out channel: out_valid / out_ready / out_ciphertext, right half in the upper 32 bits
// cfg port: cfg_we / cfg_wdata loads the 32-bit key, no read-back;
//   write it only while no word is in flight
// one register stage per round, ROUNDS stages in a row; the last stage is the
//   output register
// an accepted word passes through all ROUNDS stage registers in order to out_valid
// throughput: one word per cycle when not stalled, set by the per-round stage chain
// each stage holds a valid bit and its word; a stage takes a new word when it is
//   empty or its own word moves on, so bubbles close up during a stall
// when the receiver stalls, words pile up stage by stage and in_ready drops only
//   once every stage is full; nothing is dropped or repeated
// reset (rst_n low at a clock edge) empties all stages and clears the key to zero
`default_nettype none

module feistel_block_encrypt_unit #(
  parameter int ROUNDS = 10
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [31:0] cfg_wdata,
  input  wire logic        in_valid,
  output      logic        in_ready,
  input  wire logic [63:0] in_plaintext,
  output      logic        out_valid,
  input  wire logic        out_ready,
  output      logic [63:0] out_ciphertext
);

  logic [31:0] cipher_key_r;
  logic [31:0] cipher_key_nxt;

  // stage k feeds stage k+1; index 0 is the input port
  logic             st_valid [ROUNDS + 1];
  logic             st_ready [ROUNDS + 1];
  feb_pkg::halves_t st_data  [ROUNDS + 1];
  logic [ROUNDS-1:0] occ;

  assign cipher_key_nxt = cfg_we ? cfg_wdata : cipher_key_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cipher_key_r <= '0;
    end else begin
      cipher_key_r <= cipher_key_nxt;
    end
  end

  assign st_valid[0]      = in_valid;
  assign in_ready         = st_ready[0];
  assign st_data[0].left  = in_plaintext[63:32];
  assign st_data[0].right = in_plaintext[31:0];

  for (genvar k = 0; k < ROUNDS; k++) begin : g_round
    feb_round #(
      .ROUND_IDX(k + 1)
    ) u_round (
      .clk     (clk),
      .rst_n   (rst_n),
      .key     (cipher_key_r),
      .up_valid(st_valid[k]),
      .up_ready(st_ready[k]),
      .up_data (st_data[k]),
      .dn_valid(st_valid[k + 1]),
      .dn_ready(st_ready[k + 1]),
      .dn_data (st_data[k + 1])
    );
    assign occ[k] = st_valid[k + 1];
  end

  // final half swap
  assign st_ready[ROUNDS] = out_ready;
  assign out_valid        = st_valid[ROUNDS];
  assign out_ciphertext   = {st_data[ROUNDS].right, st_data[ROUNDS].left};

`ifndef NO_ASSERTIONS
  // occupancy grows by at most the one accepted word per cycle
  a_occ_growth: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(occ) <= $past($countones(occ)) + 1)
    else $error("pipeline gained more than one word in a cycle");

  // a full pipeline with a stalled receiver takes nothing new
  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (&occ && !out_ready) |-> !in_ready)
    else $error("input accepted while pipeline full and stalled");

  // a word in the first stage that cannot move stays put
  a_first_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (st_valid[1] && !st_ready[1]) |=> (st_valid[1] && $stable(st_data[1])))
    else $error("first stage lost or changed a held word");

  // nothing comes out in the cycle after reset
  a_reset_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !$past(rst_n) |-> !out_valid)
    else $error("output valid right after reset");
`endif

endmodule

`default_nettype wire
